// ----- rtl/core/fijb_pkg.sv -----
// ----------------------------------------------------------------------------
// fijb_pkg
// Shared widths, operation codes, controller states and the result word type
// of the frame indexed command jitter buffer.
// ----------------------------------------------------------------------------
package fijb_pkg;

  localparam int MODE_W  = 2;
  localparam int FRAME_W = 16;
  localparam int CMD_W   = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT  = 2'd0,
    MODE_TAKE = 2'd1,
    MODE_FIND = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command_out;
    logic             predicted;
  } res_t;

endpackage

// ----- rtl/core/fijb_if.sv -----
// ----------------------------------------------------------------------------
// fijb interfaces
// Valid/ready channels for the operation words going in and the result
// words coming out.
// ----------------------------------------------------------------------------
interface fijb_in_if;
  import fijb_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FRAME_W-1:0] frame;
  logic [CMD_W-1:0]   command_word;

  modport source (output valid, output mode, output frame, output command_word, input ready);
  modport sink   (input valid, input mode, input frame, input command_word, output ready);
endinterface

interface fijb_out_if;
  import fijb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command_out;
  logic             predicted;

  modport source (output valid, output command_out, output predicted, input ready);
  modport sink   (input valid, input command_out, input predicted, output ready);
endinterface

// ----- rtl/core/fijb_ram.sv -----
// ----------------------------------------------------------------------------
// fijb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fijb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/fijb_ctrl.sv -----
// ----------------------------------------------------------------------------
// fijb_ctrl
// Queue pointers, frame bookkeeping and the read sequencer that drives the
// command store and hands finished results to the output stage.
// ----------------------------------------------------------------------------
module fijb_ctrl #(
  parameter int DEPTH     = 64,
  parameter int CMD_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fijb_pkg::CMD_W-1:0]         cfg_wdata_i,
  fijb_in_if.sink                            in_i,
  input  logic                               res_ready_i,
  output logic                               res_valid_o,
  output fijb_pkg::res_t                     res_o,
  output logic                               mem_we_o,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr_o,
  output logic [((CMD_WIDTH < fijb_pkg::CMD_W) ? CMD_WIDTH : fijb_pkg::CMD_W)-1:0] mem_wdata_o,
  output logic                               mem_re_o,
  output logic [$clog2(DEPTH)-1:0]           mem_raddr_o,
  input  logic [((CMD_WIDTH < fijb_pkg::CMD_W) ? CMD_WIDTH : fijb_pkg::CMD_W)-1:0] mem_rdata_i
);
  import fijb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CMD_WIDTH < CMD_W) ? CMD_WIDTH : CMD_W;

  // ring slot of an offset from the read index, offset at most DEPTH
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic [FRAME_W-1:0] first_q, first_d;
  logic [SW-1:0]      last_q, last_d;
  logic               taken_q, taken_d;
  logic               pend_mem_q, pend_mem_d;
  logic               pend_pred_q, pend_pred_d;
  logic               pend_take_q, pend_take_d;

  mode_e              mode_s;
  logic               acc;
  logic               res_load;
  logic [FRAME_W-1:0] offset;
  logic [FRAME_W-1:0] next_frame;
  logic [CW-1:0]      off_c;
  logic [CW-1:0]      removed;
  logic               behind;
  logic               hit;
  logic               count_nz;
  logic               full;
  logic               put_ok;

  assign mode_s     = mode_e'(in_i.mode);
  assign in_i.ready = (state_q == ST_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign res_load   = (state_q == ST_READ) && res_ready_i;

  // wrap-around distance from the first queued frame
  assign offset     = in_i.frame - first_q;
  assign behind     = offset[FRAME_W-1];
  assign hit        = !behind && (offset < FRAME_W'(count_q));
  assign off_c      = CW'(offset);
  assign count_nz   = (count_q != '0);
  assign full       = (count_q == CW'(DEPTH));
  assign next_frame = first_q + FRAME_W'(count_q);
  assign removed    = hit ? (off_c + CW'(1)) : count_q;
  assign put_ok     = !count_nz || (next_frame == in_i.frame);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && ((mode_s == MODE_TAKE) || (mode_s == MODE_FIND))) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = slot(rd_idx_q, count_q);
    mem_wdata_o = SW'(in_i.command_word);
    mem_re_o    = 1'b0;
    mem_raddr_o = slot(rd_idx_q, off_c);
    rd_idx_d    = rd_idx_q;
    count_d     = count_q;
    first_d     = first_q;
    last_d      = last_q;
    taken_d     = taken_q;
    pend_mem_d  = pend_mem_q;
    pend_pred_d = pend_pred_q;
    pend_take_d = pend_take_q;

    if (cfg_we_i && !taken_q) begin
      last_d = SW'(cfg_wdata_i);
    end

    if (acc) begin
      unique case (mode_s)
        MODE_PUT: begin
          if (put_ok) begin
            if (!count_nz) begin
              first_d = in_i.frame;
            end
            if (!full) begin
              mem_we_o = 1'b1;
              count_d  = count_q + CW'(1);
            end
          end
        end
        MODE_TAKE: begin
          pend_take_d = 1'b1;
          pend_pred_d = !hit;
          pend_mem_d  = 1'b0;
          if (!behind && (removed != '0)) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = slot(rd_idx_q, removed - CW'(1));
            pend_mem_d  = 1'b1;
            rd_idx_d    = slot(rd_idx_q, removed);
            count_d     = count_q - removed;
            first_d     = first_q + FRAME_W'(removed);
          end
        end
        MODE_FIND: begin
          pend_take_d = 1'b0;
          pend_pred_d = !hit;
          pend_mem_d  = 1'b0;
          if (hit) begin
            mem_re_o   = 1'b1;
            pend_mem_d = 1'b1;
          end else if (!behind && count_nz) begin
            // no match: newest entry stands in
            mem_re_o    = 1'b1;
            mem_raddr_o = slot(rd_idx_q, count_q - CW'(1));
            pend_mem_d  = 1'b1;
          end
        end
        MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end

    if (res_load && pend_take_q && pend_mem_q) begin
      last_d  = mem_rdata_i;
      taken_d = 1'b1;
    end
  end

  assign res_valid_o       = (state_q == ST_READ);
  assign res_o.command_out = CMD_W'(pend_mem_q ? mem_rdata_i : last_q);
  assign res_o.predicted   = pend_pred_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      count_q     <= '0;
      first_q     <= '0;
      last_q      <= '0;
      taken_q     <= 1'b0;
      pend_mem_q  <= 1'b0;
      pend_pred_q <= 1'b0;
      pend_take_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      count_q     <= count_d;
      first_q     <= first_d;
      last_q      <= last_d;
      taken_q     <= taken_d;
      pend_mem_q  <= pend_mem_d;
      pend_pred_q <= pend_pred_d;
      pend_take_q <= pend_take_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond store depth");

  a_rd_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(rd_idx_q) < CW'(DEPTH))
    else $error("read index outside the ring");

  a_lookup_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && ((mode_s == MODE_TAKE) || (mode_s == MODE_FIND))) |=> (state_q == ST_READ))
    else $error("lookup word did not start a store read");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode_s == MODE_PUT) && put_ok && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("in-sequence put did not grow the queue");

  a_taken_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q |=> taken_q)
    else $error("taken flag cleared outside reset");

endmodule

// ----- rtl/core/frame_indexed_command_jitter_buffer.sv -----
// ----------------------------------------------------------------------------
// frame_indexed_command_jitter_buffer
// Put words append in-sequence commands to a ring store; take and find words
// look a frame up and return the stored or the predicted command.
// ----------------------------------------------------------------------------
// Put and unused-mode words leave the controller idle, so one word may follow per
// cycle. Take and find words hold the input through a store read, then the output
// register takes the result; the store's registered read sets this, and output
// stalls extend it. Reset clears pointers, count, first frame and the held command
// at once; the store itself is not cleared and only occupied slots are ever read.
module frame_indexed_command_jitter_buffer #(
  parameter int DEPTH     = 64,
  parameter int CMD_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fijb_pkg::CMD_W-1:0] cfg_wdata_i,
  fijb_in_if.sink                    in_i,
  fijb_out_if.source                 out_o
);
  import fijb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (CMD_WIDTH < CMD_W) ? CMD_WIDTH : CMD_W;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [SW-1:0] mem_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;

  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  fijb_ctrl #(
    .DEPTH     (DEPTH),
    .CMD_WIDTH (CMD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fijb_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register takes a new word when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.command_out = out_res_q.command_out;
  assign out_o.predicted   = out_res_q.predicted;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the frame indexed command jitter buffer. A directed table covers the
// reset value, the wrapping frame compare, out-of-sequence puts and the default
// command register. Bursts of random, mostly in-sequence put, take and find
// words follow. Every result word is compared with the table's expected value
// or a shadow of the buffer.
module testbench;
  import fijb_pkg::*;

  localparam int DEPTH = 64;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    mode_e              mode;
    logic [FRAME_W-1:0] frame;
    logic [CMD_W-1:0]   value;
    logic               typed;
    res_t               want;
  } row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CMD_W-1:0] cfg_wdata_i;

  fijb_in_if  word_in();
  fijb_out_if word_out();

  frame_indexed_command_jitter_buffer #(
    .DEPTH     (DEPTH),
    .CMD_WIDTH (CMD_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (word_in),
    .out_o       (word_out)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // shadow of the buffer contents
  logic [CMD_W-1:0]   shadow_store [DEPTH];
  logic [5:0]         shadow_rd    = '0;
  logic [6:0]         shadow_count = '0;
  logic [FRAME_W-1:0] shadow_first = '0;
  logic [CMD_W-1:0]   held_command = '0;
  bit                 taken_any    = 1'b0;

  res_t        due_results [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  rx_pattern_e rx_pattern = RX_OPEN;
  int unsigned rx_left    = 0;
  int unsigned rx_cycle   = 0;

  row_t dir_rows [22] = '{
    '{ROW_WORD, MODE_TAKE, 16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{ROW_WORD, MODE_FIND, 16'h8000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{ROW_WORD, MODE_NONE, 16'hffff, 32'hffff_ffff, 1'b0, '{32'h0000_0000, 1'b0}},
    // default command written before anything was taken
    '{ROW_CFG,  MODE_PUT,  16'h0000, 32'hffff_ffff, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_FIND, 16'h1234, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1}},
    // three puts across the frame wrap, then one out of sequence
    '{ROW_WORD, MODE_PUT,  16'hfffe, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_PUT,  16'hffff, 32'hffff_ffff, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_PUT,  16'h0000, 32'ha5a5_a5a5, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_PUT,  16'h0005, 32'h1111_1111, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_FIND, 16'hffff, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b0}},
    '{ROW_WORD, MODE_FIND, 16'h0003, 32'h0000_0000, 1'b1, '{32'ha5a5_a5a5, 1'b1}},
    // last frame still counted as ahead, then the first one counted as behind
    '{ROW_WORD, MODE_FIND, 16'h7ffd, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_FIND, 16'h7ffe, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1}},
    '{ROW_WORD, MODE_TAKE, 16'hfffe, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    '{ROW_CFG,  MODE_PUT,  16'h0000, 32'h5a5a_5a5a, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_TAKE, 16'hfffd, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{ROW_WORD, MODE_TAKE, 16'h0010, 32'h0000_0000, 1'b1, '{32'ha5a5_a5a5, 1'b1}},
    '{ROW_WORD, MODE_TAKE, 16'h0001, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_PUT,  16'h8000, 32'h0000_0001, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_PUT,  16'h8001, 32'h8000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_TAKE, 16'h8001, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
    '{ROW_WORD, MODE_NONE, 16'h0000, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}}
  };

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic step_buffer(input mode_e m, input logic [FRAME_W-1:0] f,
                             input logic [CMD_W-1:0] c, output bit has_res, output res_t r);
    logic [FRAME_W-1:0] off;
    logic [6:0]         removed;
    has_res = 1'b0;
    r       = '0;
    off     = f - shadow_first;
    case (m)
      MODE_PUT: begin
        // an empty queue takes any frame as its first
        if (shadow_count == 0) shadow_first = f;
        if (f == shadow_first + FRAME_W'(shadow_count) && shadow_count < DEPTH) begin
          shadow_store[shadow_rd + 6'(shadow_count)] = c;
          shadow_count++;
        end
      end
      MODE_TAKE, MODE_FIND: begin
        has_res = 1'b1;
        if (off[FRAME_W-1]) begin
          r = '{held_command, 1'b1};
        end else if (m == MODE_TAKE) begin
          if (off < FRAME_W'(shadow_count)) begin
            removed     = 7'(off) + 7'd1;
            r.predicted = 1'b0;
          end else begin
            removed     = shadow_count;
            r.predicted = 1'b1;
          end
          if (removed != 0) begin
            held_command  = shadow_store[shadow_rd + 6'(removed - 7'd1)];
            taken_any     = 1'b1;
            shadow_rd    += 6'(removed);
            shadow_count -= removed;
            shadow_first += FRAME_W'(removed);
          end
          r.command_out = held_command;
        end else if (off < FRAME_W'(shadow_count)) begin
          r = '{shadow_store[shadow_rd + 6'(off)], 1'b0};
        end else if (shadow_count == 0) begin
          r = '{held_command, 1'b1};
        end else begin
          r = '{shadow_store[shadow_rd + 6'(shadow_count - 7'd1)], 1'b1};
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input mode_e m, input logic [FRAME_W-1:0] f,
                           input logic [CMD_W-1:0] c, input bit typed, input res_t want);
    bit   has_res;
    res_t r;
    word_in.valid        <= 1'b1;
    word_in.mode         <= m;
    word_in.frame        <= f;
    word_in.command_word <= c;
    do @(posedge clk_i); while (word_in.ready !== 1'b1);
    step_buffer(m, f, c, has_res, r);
    if (has_res) due_results.push_back(typed ? want : r);
  endtask

  task automatic write_default(input logic [CMD_W-1:0] v);
    word_in.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // a trailing put has no result, give it time to land
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    if (!taken_any) held_command = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic next_slot();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        word_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_left == 0) begin
      rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
      rx_left    <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_pattern)
      RX_OPEN:   word_out.ready <= 1'b1;
      RX_COIN:   word_out.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: word_out.ready <= (rx_cycle[1:0] == 2'd0);
      default:   word_out.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && word_out.valid === 1'b1 && word_out.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch("result word with no command pending");
      end else begin
        want = due_results.pop_front();
        if (word_out.command_out !== want.command_out)
          report_mismatch($sformatf("command_out %h, expected %h",
                                    word_out.command_out, want.command_out));
        if (word_out.predicted !== want.predicted)
          report_mismatch($sformatf("predicted %b, expected %b",
                                    word_out.predicted, want.predicted));
      end
    end
  end

  initial begin
    logic [FRAME_W-1:0] tail;
    logic [FRAME_W-1:0] f;
    mode_e              m;
    int unsigned        pick;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    word_in.valid        <= 1'b0;
    word_in.mode         <= MODE_PUT;
    word_in.frame        <= '0;
    word_in.command_word <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_default(dir_rows[i].value);
      end else begin
        send_word(dir_rows[i].mode, dir_rows[i].frame, dir_rows[i].value,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_default('0);
        1:       write_default('1);
        2:       write_default($urandom);
        default: write_default(32'h8000_0001);
      endcase
      // run the store past full so the surplus puts get dropped
      if (phase % 2 == 0) begin
        repeat (DEPTH + 3) begin
          next_slot();
          f = (shadow_count == 0) ? FRAME_W'($urandom) : shadow_first + FRAME_W'(shadow_count);
          send_word(MODE_PUT, f, $urandom, 1'b0, '0);
        end
      end
      repeat (150) begin
        next_slot();
        pick = $urandom_range(0, 99);
        tail = shadow_first + FRAME_W'(shadow_count);
        m    = ($urandom_range(0, 1) == 0) ? MODE_TAKE : MODE_FIND;
        if (pick < 45) begin
          m = MODE_PUT;
          f = (shadow_count == 0) ? FRAME_W'($urandom) : tail;
        end else if (pick < 75) begin
          f = shadow_first + FRAME_W'($urandom_range(0, (shadow_count == 0) ? 0 : shadow_count - 1));
        end else if (pick < 81) begin
          f = tail + FRAME_W'($urandom_range(0, 40));
        end else if (pick < 84) begin
          f = shadow_first + FRAME_W'($urandom_range(shadow_count, 16'h7fff));
        end else if (pick < 89) begin
          // behind the first frame by the wrapping compare
          f = shadow_first - FRAME_W'($urandom_range(1, 16'h8000));
        end else if (pick < 93) begin
          m = MODE_PUT;
          f = tail + FRAME_W'($urandom_range(1, 16'hffff));
        end else if (pick < 96) begin
          m = MODE_NONE;
          f = FRAME_W'($urandom);
        end else begin
          m = mode_e'($urandom_range(0, 3));
          f = FRAME_W'($urandom);
        end
        send_word(m, f, $urandom, 1'b0, '0);
      end
    end

    word_in.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- frame_indexed_command_jitter_buffer.f -----
rtl/core/fijb_pkg.sv
rtl/core/fijb_if.sv
rtl/core/fijb_ram.sv
rtl/core/fijb_ctrl.sv
rtl/core/frame_indexed_command_jitter_buffer.sv
tb/testbench.sv
